/* design/lpw_pkg.sv */
// Shared types and constants for the line pixel walker.
// No dependencies; every other file of the block imports this package.
package lpw_pkg;

    // Width of the screen size registers.
    localparam int SCREEN_BITS = 12;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    // Screen size after reset.
    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 12'd640;
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd480;

    // Input beat kinds.
    typedef enum logic
    {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } kind_t;

    // Per-pixel status flags from the step datapath.
    typedef struct packed
    {
        logic visible;
        logic last;
    } pix_flags_t;

endpackage

/* design/line_pixel_walker_core.sv */
// Top level of the line pixel walker: input register, walk state, result
// register and screen size registers. Uses lpw_pkg, lpw_setup and lpw_step.
//
//  Channel   Signals                                    Direction
//  in        in_valid/in_ready, kind, x/y_start/end,   into block
//            colour_in
//  out       out_valid/out_ready, pixel_x/y,            out of block
//            pixel_colour, visible, last
//  cfg       cfg_valid/cfg_ready, cfg_index, cfg_data   into block
//
// One beat is accepted per cycle while in_ready is high; a step beat gives its pixel
// through the input register, then the result register. The walk state update
// in lpw_step is pure combinational logic.
// Reset clears the walk state and output valid and sets the screen to 640x480.
// A stalled result holds; in_ready drops only while a step beat waits in the
// input register behind a result that has not been taken.
module line_pixel_walker_core #(
    parameter int COORD_BITS = 13
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  kind,
    input  logic signed [COORD_BITS-1:0]          x_start,
    input  logic signed [COORD_BITS-1:0]          y_start,
    input  logic signed [COORD_BITS-1:0]          x_end,
    input  logic signed [COORD_BITS-1:0]          y_end,
    input  logic        [31:0]                    colour_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [COORD_BITS-1:0]          pixel_x,
    output logic signed [COORD_BITS-1:0]          pixel_y,
    output logic        [31:0]                    pixel_colour,
    output logic                                  visible,
    output logic                                  last,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [lpw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic        [lpw_pkg::SCREEN_BITS-1:0]    cfg_data
);
    import lpw_pkg::*;

    localparam int SPAN_W  = COORD_BITS + 1;
    localparam int DELTA_W = COORD_BITS + 2;

    // Input register.
    logic                         in_valid_reg;
    kind_t                        kind_reg;
    logic signed [COORD_BITS-1:0] x_start_reg;
    logic signed [COORD_BITS-1:0] y_start_reg;
    logic signed [COORD_BITS-1:0] x_end_reg;
    logic signed [COORD_BITS-1:0] y_end_reg;
    logic        [31:0]           colour_reg;

    // Walk state.
    logic                         walking_reg;
    logic                         major_is_y_reg;
    logic signed [COORD_BITS-1:0] major_pos_reg;
    logic signed [COORD_BITS-1:0] major_stop_reg;
    logic signed [COORD_BITS-1:0] minor_pos_reg;
    logic        [SPAN_W-1:0]     major_span_reg;
    logic signed [DELTA_W-1:0]    minor_delta_reg;
    logic        [SPAN_W-1:0]     remainder_reg;
    logic        [31:0]           seg_colour_reg;

    // Screen size registers.
    logic [SCREEN_BITS-1:0] screen_width_reg;
    logic [SCREEN_BITS-1:0] screen_height_reg;

    // Result register.
    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] pixel_x_reg;
    logic signed [COORD_BITS-1:0] pixel_y_reg;
    logic        [31:0]           pixel_colour_reg;
    pix_flags_t                   flags_reg;

    // Setup and step outputs.
    logic                         set_major_is_y;
    logic signed [COORD_BITS-1:0] set_major_first;
    logic signed [COORD_BITS-1:0] set_major_final;
    logic signed [COORD_BITS-1:0] set_minor_first;
    logic        [SPAN_W-1:0]     set_major_span;
    logic signed [DELTA_W-1:0]    set_minor_delta;
    logic signed [COORD_BITS-1:0] stp_x;
    logic signed [COORD_BITS-1:0] stp_y;
    pix_flags_t                   stp_flags;
    logic signed [COORD_BITS-1:0] stp_major_next;
    logic signed [COORD_BITS-1:0] stp_minor_next;
    logic        [SPAN_W-1:0]     stp_remainder_next;

    logic produces;
    logic advance;

    lpw_setup #(.COORD_BITS(COORD_BITS)) u_setup (
        .x_start     (x_start_reg),
        .y_start     (y_start_reg),
        .x_end       (x_end_reg),
        .y_end       (y_end_reg),
        .major_is_y  (set_major_is_y),
        .major_first (set_major_first),
        .major_final (set_major_final),
        .minor_first (set_minor_first),
        .major_span  (set_major_span),
        .minor_delta (set_minor_delta)
    );

    lpw_step #(.COORD_BITS(COORD_BITS)) u_step (
        .major_is_y     (major_is_y_reg),
        .major_pos      (major_pos_reg),
        .major_stop     (major_stop_reg),
        .minor_pos      (minor_pos_reg),
        .major_span     (major_span_reg),
        .minor_delta    (minor_delta_reg),
        .remainder      (remainder_reg),
        .screen_width   (screen_width_reg),
        .screen_height  (screen_height_reg),
        .pix_x          (stp_x),
        .pix_y          (stp_y),
        .flags          (stp_flags),
        .major_pos_next (stp_major_next),
        .minor_pos_next (stp_minor_next),
        .remainder_next (stp_remainder_next)
    );

    // Flow control: a beat moves on unless it needs the result register
    // while that register still holds a result nobody has taken.
    assign produces  = (kind_reg == KIND_STEP) && walking_reg;
    assign advance   = in_valid_reg && (!produces || !out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg    <= kind_t'(kind);
            x_start_reg <= x_start;
            y_start_reg <= y_start;
            x_end_reg   <= x_end;
            y_end_reg   <= y_end;
            colour_reg  <= colour_in;
        end
    end

    // Screen size registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_SCREEN_WIDTH)
                screen_width_reg <= cfg_data;
            else if (cfg_index == CFG_SCREEN_HEIGHT)
                screen_height_reg <= cfg_data;
        end
    end

    // Walk state: a load starts a segment, a step advances or ends it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walking_reg     <= 1'b0;
            major_is_y_reg  <= 1'b0;
            major_pos_reg   <= '0;
            major_stop_reg  <= '0;
            minor_pos_reg   <= '0;
            major_span_reg  <= '0;
            minor_delta_reg <= '0;
            remainder_reg   <= '0;
            seg_colour_reg  <= '0;
        end
        else if (advance)
        begin
            if (kind_reg == KIND_LOAD)
            begin
                walking_reg     <= 1'b1;
                major_is_y_reg  <= set_major_is_y;
                major_pos_reg   <= set_major_first;
                major_stop_reg  <= set_major_final;
                minor_pos_reg   <= set_minor_first;
                major_span_reg  <= set_major_span;
                minor_delta_reg <= set_minor_delta;
                remainder_reg   <= '0;
                seg_colour_reg  <= colour_reg;
            end
            else if (walking_reg)
            begin
                if (stp_flags.last)
                    walking_reg <= 1'b0;
                else
                begin
                    major_pos_reg <= stp_major_next;
                    minor_pos_reg <= stp_minor_next;
                    remainder_reg <= stp_remainder_next;
                end
            end
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && produces)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance && produces)
        begin
            pixel_x_reg      <= stp_x;
            pixel_y_reg      <= stp_y;
            pixel_colour_reg <= seg_colour_reg;
            flags_reg        <= stp_flags;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign pixel_colour = pixel_colour_reg;
    assign visible      = flags_reg.visible;
    assign last         = flags_reg.last;

endmodule

/* design/lpw_setup.sv */
// Segment setup: picks the major axis, orders the endpoints and forms the
// span and signed minor step. Pure combinational logic; uses lpw_pkg.
module lpw_setup #(
    parameter int COORD_BITS = 13
) (
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    output logic                         major_is_y,
    output logic signed [COORD_BITS-1:0] major_first,
    output logic signed [COORD_BITS-1:0] major_final,
    output logic signed [COORD_BITS-1:0] minor_first,
    output logic        [COORD_BITS:0]   major_span,
    output logic signed [COORD_BITS+1:0] minor_delta
);
    import lpw_pkg::*;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int DELTA_W = COORD_BITS + 2;

    logic signed [DIFF_W-1:0]     dx_s;
    logic signed [DIFF_W-1:0]     dy_s;
    logic        [DIFF_W-1:0]     dx;
    logic        [DIFF_W-1:0]     dy;
    logic        [DIFF_W-1:0]     minor_ext;
    logic signed [DELTA_W-1:0]    minor_ext_s;
    logic signed [COORD_BITS-1:0] ma0;
    logic signed [COORD_BITS-1:0] ma1;
    logic signed [COORD_BITS-1:0] mi0;
    logic signed [COORD_BITS-1:0] mi1;

    // Extents of the segment along each axis.
    always_comb
    begin
        dx_s = DIFF_W'(x_end) - DIFF_W'(x_start);
        dy_s = DIFF_W'(y_end) - DIFF_W'(y_start);
        dx   = dx_s[DIFF_W-1] ? DIFF_W'(-dx_s) : DIFF_W'(dx_s);
        dy   = dy_s[DIFF_W-1] ? DIFF_W'(-dy_s) : DIFF_W'(dy_s);
    end

    // Axis choice (x wins ties) and endpoint ordering along the major axis.
    always_comb
    begin
        major_is_y = (dx < dy);
        if (major_is_y)
        begin
            ma0        = y_start;
            ma1        = y_end;
            mi0        = x_start;
            mi1        = x_end;
            major_span = dy;
            minor_ext  = dx;
        end
        else
        begin
            ma0        = x_start;
            ma1        = x_end;
            mi0        = y_start;
            mi1        = y_end;
            major_span = dx;
            minor_ext  = dy;
        end

        if (ma0 > ma1)
        begin
            major_first = ma1;
            major_final = ma0;
            minor_first = mi1;
            minor_ext_s = (mi0 >= mi1) ? $signed(DELTA_W'(minor_ext))
                                       : -$signed(DELTA_W'(minor_ext));
        end
        else
        begin
            major_first = ma0;
            major_final = ma1;
            minor_first = mi0;
            minor_ext_s = (mi1 >= mi0) ? $signed(DELTA_W'(minor_ext))
                                       : -$signed(DELTA_W'(minor_ext));
        end
        minor_delta = minor_ext_s;
    end

endmodule

/* design/lpw_step.sv */
// Step datapath: forms one pixel from the walk state and the next walk
// state. Pure combinational logic; uses lpw_pkg.
module lpw_step #(
    parameter int COORD_BITS = 13
) (
    input  logic                                major_is_y,
    input  logic signed [COORD_BITS-1:0]        major_pos,
    input  logic signed [COORD_BITS-1:0]        major_stop,
    input  logic signed [COORD_BITS-1:0]        minor_pos,
    input  logic        [COORD_BITS:0]          major_span,
    input  logic signed [COORD_BITS+1:0]        minor_delta,
    input  logic        [COORD_BITS:0]          remainder,
    input  logic        [lpw_pkg::SCREEN_BITS-1:0] screen_width,
    input  logic        [lpw_pkg::SCREEN_BITS-1:0] screen_height,
    output logic signed [COORD_BITS-1:0]        pix_x,
    output logic signed [COORD_BITS-1:0]        pix_y,
    output lpw_pkg::pix_flags_t                 flags,
    output logic signed [COORD_BITS-1:0]        major_pos_next,
    output logic signed [COORD_BITS-1:0]        minor_pos_next,
    output logic        [COORD_BITS:0]          remainder_next
);
    import lpw_pkg::*;

    localparam int SPAN_W = COORD_BITS + 1;
    localparam int SUM_W  = SPAN_W + 2;
    localparam int CMP_W  = ((COORD_BITS > SCREEN_BITS + 1) ? COORD_BITS : SCREEN_BITS + 1) + 1;

    logic                         round_wanted;
    logic        [SCREEN_BITS-1:0] limit;
    logic signed [CMP_W-1:0]      limit_m1;
    logic signed [CMP_W-1:0]      minor_w;
    logic signed [CMP_W-1:0]      px_w;
    logic signed [CMP_W-1:0]      py_w;
    logic signed [COORD_BITS-1:0] minor_round;
    logic signed [SUM_W-1:0]      sum;
    logic signed [SUM_W-1:0]      span_s;

    // Round to nearest, halves down, held back at the screen edge minus one.
    always_comb
    begin
        round_wanted = ({remainder, 1'b0} > {1'b0, major_span});
        limit        = major_is_y ? screen_width : screen_height;
        limit_m1     = $signed(CMP_W'(limit)) - $signed(CMP_W'(1));
        minor_w      = CMP_W'(minor_pos);
        if (round_wanted && (minor_w < limit_m1))
            minor_round = minor_pos + COORD_BITS'(1);
        else
            minor_round = minor_pos;
    end

    // Pixel position and its flags.
    always_comb
    begin
        pix_x         = major_is_y ? minor_round : major_pos;
        pix_y         = major_is_y ? major_pos : minor_round;
        px_w          = CMP_W'(pix_x);
        py_w          = CMP_W'(pix_y);
        flags.visible = (px_w >= 0) && (px_w < $signed(CMP_W'(screen_width)))
                     && (py_w >= 0) && (py_w < $signed(CMP_W'(screen_height)));
        flags.last    = (major_pos >= major_stop);
    end

    // Exact incremental update of the minor coordinate.
    always_comb
    begin
        major_pos_next = major_pos + COORD_BITS'(1);
        sum            = $signed(SUM_W'(remainder)) + SUM_W'(minor_delta);
        span_s         = $signed(SUM_W'(major_span));
        if ((major_span != '0) && (sum >= span_s))
        begin
            remainder_next = SPAN_W'(sum - span_s);
            minor_pos_next = minor_pos + COORD_BITS'(1);
        end
        else if (sum < 0)
        begin
            remainder_next = SPAN_W'(sum + span_s);
            minor_pos_next = minor_pos - COORD_BITS'(1);
        end
        else
        begin
            remainder_next = SPAN_W'(sum);
            minor_pos_next = minor_pos;
        end
    end

endmodule

/* design/lpw_checker.sv */
// Port-level checks for line_pixel_walker_core, with the bind that attaches
// them. Uses lpw_pkg.
module lpw_checker #(
    parameter int COORD_BITS = 13
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  kind,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [COORD_BITS-1:0] pixel_x,
    input logic [COORD_BITS-1:0] pixel_y,
    input logic [31:0]           pixel_colour,
    input logic                  visible,
    input logic                  last
);
    import lpw_pkg::*;

    // No result is offered right after reset has been sampled applied.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result offered during reset");

    // A result that has not been taken keeps its beat unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(pixel_colour) && $stable(visible) && $stable(last))
        else $error("stalled result changed");

    // A visible pixel never has a negative coordinate.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && visible |-> !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1])
        else $error("visible pixel with negative coordinate");

    // A fresh result comes from a step beat, via input register then result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2) && ($past(kind, 2) == KIND_STEP))
        else $error("result without a step beat");

endmodule

bind line_pixel_walker_core lpw_checker #(.COORD_BITS(COORD_BITS)) u_lpw_checker (.*);

/* bench/line_walk_checker.sv */
// Pixel checker for the line pixel walker: follows the input, result and register channels,
// predicts every pixel and compares it field by field with what the block hands out.
// Depends on lpw_pkg for the beat kinds, register indexes and screen size defaults.
`timescale 1ns / 100ps

module line_walk_checker #(
    parameter int COORD_BITS = 13
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic                                  kind,
    input  logic signed [COORD_BITS-1:0]          x_start,
    input  logic signed [COORD_BITS-1:0]          y_start,
    input  logic signed [COORD_BITS-1:0]          x_end,
    input  logic signed [COORD_BITS-1:0]          y_end,
    input  logic        [31:0]                    colour_in,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [COORD_BITS-1:0]          pixel_x,
    input  logic signed [COORD_BITS-1:0]          pixel_y,
    input  logic        [31:0]                    pixel_colour,
    input  logic                                  visible,
    input  logic                                  last,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic        [lpw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic        [lpw_pkg::SCREEN_BITS-1:0]    cfg_data,
    output int                                    fail_count,
    output int                                    pixels_due
);

    import lpw_pkg::*;

    // One pixel as the block reports it.
    typedef struct packed
    {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [31:0]           colour;
        logic                  visible;
        logic                  last;
    } pixel_t;

    // Screen size as last written.
    logic [SCREEN_BITS-1:0] scr_w;
    logic [SCREEN_BITS-1:0] scr_h;

    // Walk state; minor_delta one bit narrower, remainder one bit wider than the block's.
    logic                         walking;
    logic                         major_is_y;
    logic signed [COORD_BITS-1:0] major_pos;
    logic signed [COORD_BITS-1:0] major_stop;
    logic signed [COORD_BITS-1:0] minor_pos;
    logic        [COORD_BITS:0]   major_span;
    logic signed [COORD_BITS:0]   minor_delta;
    logic signed [COORD_BITS+1:0] remainder;
    logic        [31:0]           seg_colour;

    pixel_t expected_pixels[$];
    int     fails = 0;

    // Prints one line for a failure and counts it; the print is capped to keep the log short.
    task automatic report(input string what);
        fails++;
        if (fails <= 40)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Latches a new segment, ordered so that the major axis runs upward.
    task automatic start_segment(input int x0, input int y0, input int x1, input int y1,
                                 input logic [31:0] col);
        int dx, dy, ma0, mi0, ma1, mi1, span, mext, t;
        dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
        dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
        if (dx >= dy)
        begin
            major_is_y = 1'b0;
            ma0 = x0; mi0 = y0; ma1 = x1; mi1 = y1;
            span = dx; mext = dy;
        end
        else
        begin
            major_is_y = 1'b1;
            ma0 = y0; mi0 = x0; ma1 = y1; mi1 = x1;
            span = dy; mext = dx;
        end
        if (ma0 > ma1)
        begin
            t = ma0; ma0 = ma1; ma1 = t;
            t = mi0; mi0 = mi1; mi1 = t;
        end
        major_pos   = ma0[COORD_BITS-1:0];
        major_stop  = ma1[COORD_BITS-1:0];
        minor_pos   = mi0[COORD_BITS-1:0];
        major_span  = span[COORD_BITS:0];
        t           = (mi1 >= mi0) ? mext : -mext;
        minor_delta = t[COORD_BITS:0];
        remainder   = '0;
        seg_colour  = col;
        walking     = 1'b1;
    endtask

    // Works out the next pixel; advances the walk one major step, or ends it on the last.
    task automatic next_pixel();
        int     limit, mn, px, py, rem, span;
        logic   fin;
        pixel_t p;
        span  = int'(major_span);
        limit = major_is_y ? int'(scr_w) : int'(scr_h);
        mn    = int'(minor_pos);
        // Round to nearest with halves going down, but never past the screen edge.
        if (2 * int'(remainder) > span && mn < limit - 1)
            mn++;
        px  = major_is_y ? mn : int'(major_pos);
        py  = major_is_y ? int'(major_pos) : mn;
        fin = (major_pos >= major_stop);
        p.x       = px[COORD_BITS-1:0];
        p.y       = py[COORD_BITS-1:0];
        p.colour  = seg_colour;
        p.visible = (px >= 0 && px < int'(scr_w) && py >= 0 && py < int'(scr_h));
        p.last    = fin;
        expected_pixels.push_back(p);
        if (fin)
            walking = 1'b0;
        else
        begin
            major_pos = major_pos + 1'b1;
            rem = int'(remainder) + int'(minor_delta);
            if (span > 0 && rem >= span)
            begin
                rem -= span;
                minor_pos = minor_pos + 1'b1;
            end
            else if (rem < 0)
            begin
                rem += span;
                minor_pos = minor_pos - 1'b1;
            end
            remainder = rem[COORD_BITS+1:0];
        end
    endtask

    // Compares a pixel taken from the block with the oldest one expected.
    task automatic compare_pixel(input pixel_t got);
        pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            report($sformatf("pixel (%0d,%0d) arrived with nothing expected",
                             $signed(got.x), $signed(got.y)));
            return;
        end
        want = expected_pixels.pop_front();
        if (got.x !== want.x)
            report($sformatf("pixel_x got %0d want %0d", $signed(got.x), $signed(want.x)));
        if (got.y !== want.y)
            report($sformatf("pixel_y got %0d want %0d", $signed(got.y), $signed(want.y)));
        if (got.colour !== want.colour)
            report($sformatf("pixel_colour got %h want %h", got.colour, want.colour));
        if (got.visible !== want.visible)
            report($sformatf("visible got %b want %b at (%0d,%0d)", got.visible,
                             want.visible, $signed(want.x), $signed(want.y)));
        if (got.last !== want.last)
            report($sformatf("last got %b want %b at (%0d,%0d)", got.last, want.last,
                             $signed(want.x), $signed(want.y)));
    endtask

    // All three channels are sampled at the clock edge on which their beats complete.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w       = SCREEN_WIDTH_RESET;
            scr_h       = SCREEN_HEIGHT_RESET;
            walking     = 1'b0;
            major_is_y  = 1'b0;
            major_pos   = '0;
            major_stop  = '0;
            minor_pos   = '0;
            major_span  = '0;
            minor_delta = '0;
            remainder   = '0;
            seg_colour  = '0;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  scr_w = cfg_data;
                    CFG_SCREEN_HEIGHT: scr_h = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (kind == KIND_LOAD)
                    start_segment(int'(x_start), int'(y_start), int'(x_end), int'(y_end),
                                  colour_in);
                else if (walking)
                    next_pixel();
            end
            if (out_valid && out_ready)
                compare_pixel({pixel_x, pixel_y, pixel_colour, visible, last});
        end
        fail_count <= fails;
        pixels_due <= expected_pixels.size();
    end

endmodule

/* bench/testbench.sv */
// Top of the line pixel walker bench: clock, reset, segment stimulus, result stalls and verdict.
// Depends on lpw_pkg, line_pixel_walker_core and the line_walk_checker module.
`timescale 1ns / 100ps

module testbench;

    import lpw_pkg::*;

    localparam int COORD_BITS   = 13;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASES       = 6;
    localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;

    // Register indexes that the block does not implement.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          kind = KIND_LOAD;
    logic signed [COORD_BITS-1:0]  x_start = '0;
    logic signed [COORD_BITS-1:0]  y_start = '0;
    logic signed [COORD_BITS-1:0]  x_end = '0;
    logic signed [COORD_BITS-1:0]  y_end = '0;
    logic        [31:0]            colour_in = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic        [31:0]            pixel_colour;
    logic                          visible;
    logic                          last;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     cfg_index = CFG_SCREEN_WIDTH;
    logic [SCREEN_BITS-1:0]        cfg_data = '0;
    int                            fail_count;
    int                            pixels_due;

    // Sender pacing, what is left of the current segment, and the screen as last written.
    int burst_left = 0;
    int pixels_left = 0;
    int counted = 0;
    int scr_w_now = 640;
    int scr_h_now = 480;
    int cycle_count = 0;

    line_pixel_walker_core #(
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .x_start      (x_start),
        .y_start      (y_start),
        .x_end        (x_end),
        .y_end        (y_end),
        .colour_in    (colour_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_colour (pixel_colour),
        .visible      (visible),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    line_walk_checker #(
        .COORD_BITS (COORD_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .x_start      (x_start),
        .y_start      (y_start),
        .x_end        (x_end),
        .y_end        (y_end),
        .colour_in    (colour_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_colour (pixel_colour),
        .visible      (visible),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pixels_due   (pixels_due)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result stalls: the receiver switches between steady, random, sparse and stingy modes.
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 120);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= (stall_tick % 4 == 0);
            default: out_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    function automatic int clamp_coord(input int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic int span_of(input int xs, input int ys, input int xe, input int ye);
        int dx, dy;
        dx = (xe >= xs) ? xe - xs : xs - xe;
        dy = (ye >= ys) ? ye - ys : ys - ye;
        return (dx >= dy) ? dx : dy;
    endfunction

    // Drives one input beat, with a random gap at the start of most bursts, and waits for
    // it to be taken. Valid stays high into the next beat unless a gap follows.
    task automatic send_beat(input kind_t k, input int xs, input int ys, input int xe,
                             input int ye, input logic [31:0] col);
        int idle;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                idle = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        kind      <= k;
        x_start   <= xs[COORD_BITS-1:0];
        y_start   <= ys[COORD_BITS-1:0];
        x_end     <= xe[COORD_BITS-1:0];
        y_end     <= ye[COORD_BITS-1:0];
        colour_in <= col;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic load_seg(input int xs, input int ys, input int xe, input int ye,
                            input logic [31:0] col);
        pixels_left = span_of(xs, ys, xe, ye) + 1;
        counted++;
        send_beat(KIND_LOAD, xs, ys, xe, ye, col);
    endtask

    // Step beats carry random junk in the unused fields; steps past the end are not counted.
    task automatic walk(input int n);
        repeat (n)
        begin
            if (pixels_left > 0)
            begin
                pixels_left--;
                counted++;
            end
            send_beat(KIND_STEP, int'($urandom), int'($urandom), int'($urandom),
                      int'($urandom), $urandom);
        end
    endtask

    // Lets every expected pixel drain and the pipeline empty before a register write.
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pixels_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[SCREEN_BITS-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One random segment and its steps: mostly short segments around the screen, some
    // straight runs and edge-hugging slopes, some anywhere in the coordinate range.
    task automatic random_segment();
        int style, xs, ys, xe, ye, d, dm, ext, n, r;
        style = $urandom_range(0, 99);
        xs = int'($urandom_range(0, scr_w_now + 31)) - 16;
        ys = int'($urandom_range(0, scr_h_now + 31)) - 16;
        xe = xs + int'($urandom_range(0, 80)) - 40;
        ye = ys + int'($urandom_range(0, 80)) - 40;
        d  = int'($urandom_range(0, 30));
        if (style >= 45 && style < 70)
        begin
            case ($urandom_range(0, 5))
                0: ye = ys;
                1: xe = xs;
                2: begin xe = xs; ye = ys; end
                3: begin xe = xs + d; ye = ($urandom_range(0, 1) == 1) ? ys + d : ys - d; end
                4:
                begin
                    // x major, minor running along the bottom edge
                    dm = $urandom_range(0, d);
                    ys = scr_h_now - 1 - int'($urandom_range(0, 2));
                    xe = xs + d;
                    ye = ($urandom_range(0, 1) == 1) ? ys + dm : ys - dm;
                end
                default:
                begin
                    // y major (x on the tie dm == d), minor running along the right edge
                    dm = $urandom_range(0, d);
                    xs = scr_w_now - 1 - int'($urandom_range(0, 2));
                    ye = ys + d;
                    xe = ($urandom_range(0, 1) == 1) ? xs + dm : xs - dm;
                end
            endcase
        end
        else if (style >= 70 && style < 85)
        begin
            xs = int'($urandom_range(0, 8191)) + COORD_MIN;
            ys = int'($urandom_range(0, 8191)) + COORD_MIN;
            xe = xs + int'($urandom_range(0, 60)) - 30;
            ye = ys + int'($urandom_range(0, 60)) - 30;
        end
        else if (style >= 85)
        begin
            xe = int'($urandom_range(0, 8191)) + COORD_MIN;
            ye = int'($urandom_range(0, 8191)) + COORD_MIN;
        end
        xs = clamp_coord(xs);
        ys = clamp_coord(ys);
        xe = clamp_coord(xe);
        ye = clamp_coord(ye);
        if ($urandom_range(0, 1) == 1)
        begin
            d = xs; xs = xe; xe = d;
            d = ys; ys = ye; ye = d;
        end
        load_seg(xs, ys, xe, ye, $urandom);
        ext = span_of(xs, ys, xe, ye);
        r = $urandom_range(0, 99);
        if (ext > 60)
            n = $urandom_range(1, 60);
        else if (r < 15)
            n = $urandom_range(0, ext);
        else if (r < 30)
            n = ext + 1 + int'($urandom_range(1, 3));
        else
            n = ext + 1;
        walk(n);
    endtask

    // Screen settings per phase; the first phase runs with the reset values.
    int phase_w[PHASES] = '{640, 4095, 1, 0, 0, 33};
    int phase_h[PHASES] = '{480, 4095, 1, 0, 0, 4000};

    initial
    begin
        int budget;
        budget = RANDOM_ITEMS / PHASES;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: step while idle, a single point, straight runs, the rounding clip
        // at the bottom edge, an exact half going down, and the coordinate extremes.
        walk(1);
        load_seg(5, 5, 5, 5, 32'h00FF_00FF);
        walk(2);
        load_seg(3, 7, 1, 7, 32'h1234_5678);
        walk(3);
        load_seg(2, -1, 2, 1, 32'h8000_0001);
        walk(3);
        load_seg(0, 479, 3, 481, 32'hA5A5_5A5A);
        walk(4);
        load_seg(4, 0, 0, 2, 32'h0F0F_F0F0);
        walk(5);
        load_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
        walk(2);
        load_seg(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 32'h0000_0000);
        walk(1);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                settle();
                if (p == 4)
                begin
                    phase_w[p] = $urandom_range(0, 4095);
                    phase_h[p] = $urandom_range(0, 4095);
                end
                // Writes to unimplemented indexes must leave the screen alone.
                if (p == 3)
                begin
                    write_reg(CFG_SPARE_2, $urandom_range(0, 4095));
                    write_reg(CFG_SPARE_3, $urandom_range(0, 4095));
                end
                write_reg(CFG_SCREEN_WIDTH, phase_w[p]);
                write_reg(CFG_SCREEN_HEIGHT, phase_h[p]);
                scr_w_now = phase_w[p];
                scr_h_now = phase_h[p];
            end
            counted = 0;
            while (counted < budget)
                random_segment();
        end

        // Drain, then give the pipeline time to show any stray pixel.
        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pixels_due == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* line_pixel_walker_core.f */
design/lpw_pkg.sv
design/lpw_setup.sv
design/lpw_step.sv
design/line_pixel_walker_core.sv
design/lpw_checker.sv
bench/line_walk_checker.sv
bench/testbench.sv
